FILE: hdl/lkvc_pkg.sv
// Shared constants for the LRU key-value cache.
// No dependencies; every other file in hdl imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

    localparam int KEY_BITS  = 32;
    localparam int WORD_BITS = 64;
    localparam int CAP_BITS  = 5;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // Operation codes carried in the kind field.
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

endpackage

`default_nettype wire

FILE: hdl/lkvc_ifs.sv
// Valid/ready channel interfaces for the LRU key-value cache.
// Depends on lkvc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lkvc_req_if import lkvc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic signed [KEY_BITS-1:0] lookup_key;
    logic [WORD_BITS-1:0]       write_value;

    modport source (output valid, output kind, output lookup_key, output write_value,
                    input ready);
    modport sink   (input valid, input kind, input lookup_key, input write_value,
                    output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [WORD_BITS-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

interface lkvc_cfg_if import lkvc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CAP_BITS-1:0] capacity_limit;

    modport source (output valid, output capacity_limit, input ready);
    modport sink   (input valid, input capacity_limit, output ready);
endinterface

`default_nettype wire

FILE: hdl/lkvc_store.sv
// Key and value memory of the LRU key-value cache: one write port, one
// registered read port. Depends on lkvc_pkg for the key width.
`timescale 1ns / 1ps
`default_nettype none

module lkvc_store import lkvc_pkg::*; #(
    parameter int ENTRIES    = 16,
    parameter int VALUE_BITS = 64,
    parameter int ADDR_BITS  = 4
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_BITS-1:0]  wr_addr,
    input  wire logic [KEY_BITS-1:0]   wr_key,
    input  wire logic [VALUE_BITS-1:0] wr_value,
    input  wire logic                  rd_en,
    input  wire logic [ADDR_BITS-1:0]  rd_addr,
    output logic [KEY_BITS-1:0]        rd_key,
    output logic [VALUE_BITS-1:0]      rd_value
);

    logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
    logic [VALUE_BITS-1:0] value_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]   <= wr_key;
            value_mem[wr_addr] <= wr_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key   <= key_mem[rd_addr];
            rd_value <= value_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/lru_key_value_cache_top.sv
// Top level of the LRU key-value cache: sequencer, recency ranks and result register.
// Depends on lkvc_pkg, the channel interfaces in lkvc_ifs.sv and lkvc_store.
//
//   channel   direction  payload                          role
//   request   in         kind, lookup_key, write_value    get or put on one key
//   result    out        hit, read_value                  one per request
//   cap_cfg   in         capacity_limit                   entries kept before eviction
//
// Each request is accepted while idle; in the scan state the key memory's single
// read port then streams the stored keys, one entry after another, past a shared
// comparator; the drain state does the last compare, the update state updates
// the ranks and writes the memory, and the done state loads the result register
// once it is free. request.ready is high only while idle.
// The result register holds a finished result while the sequencer returns to
// idle, so the next request is taken even if the result is not yet consumed.
// Reset (rst_n low, asynchronous) empties the store at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache_top import lkvc_pkg::*; #(
    parameter int ENTRIES    = 16,
    parameter int VALUE_BITS = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lkvc_req_if.sink    request,
    lkvc_rsp_if.source  result,
    lkvc_cfg_if.sink    cap_cfg
);

    // Slot index and rank widths; the count must also hold ENTRIES itself.
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW = AW;
    localparam int CW = $clog2(ENTRIES + 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [CAP_BITS-1:0]   limit_reg;

    // Latched request.
    logic                  kind_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] wval_reg;

    // Scan address and the compare stage that trails it in the next cycle.
    logic [AW-1:0]         scan_idx_reg;
    logic                  cmp_vld_reg;
    logic [AW-1:0]         cmp_idx_reg;

    // Scan findings.
    logic                  found_reg;
    logic [AW-1:0]         hit_slot_reg;
    logic [RW-1:0]         hit_rank_reg;
    logic [VALUE_BITS-1:0] hit_val_reg;
    logic [AW-1:0]         lru_slot_reg;
    logic                  free_found_reg;
    logic [AW-1:0]         free_slot_reg;

    // Per-entry state held in flip-flops.
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [RW-1:0]         rank_reg  [ENTRIES];
    logic [RW-1:0]         rank_next [ENTRIES];
    logic [CW-1:0]         count_reg, count_next;

    // Result register.
    logic                  res_valid_reg;
    logic                  res_hit_reg;
    logic [WORD_BITS-1:0]  res_value_reg;

    // Memory ports.
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [KEY_BITS-1:0]   mem_rd_key;
    logic [VALUE_BITS-1:0] mem_rd_value;

    logic                  do_evict;
    logic [AW-1:0]         new_slot;
    logic                  cmp_entry_valid;
    logic [RW-1:0]         cmp_entry_rank;
    logic                  res_load;

    assign request.ready = (state_reg == ST_IDLE);
    assign cap_cfg.ready = 1'b1;

    assign result.valid      = res_valid_reg;
    assign result.hit        = res_hit_reg;
    assign result.read_value = res_value_reg;

    lkvc_store #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS),
        .ADDR_BITS  (AW)
    ) u_store (
        .clk      (clk),
        .wr_en    (mem_we),
        .wr_addr  (mem_waddr),
        .wr_key   (key_reg),
        .wr_value (wval_reg),
        .rd_en    (state_reg == ST_SCAN),
        .rd_addr  (scan_idx_reg),
        .rd_key   (mem_rd_key),
        .rd_value (mem_rd_value)
    );

    // The entry whose key is in the memory's read register this cycle.
    assign cmp_entry_valid = valid_reg[cmp_idx_reg];
    assign cmp_entry_rank  = rank_reg[cmp_idx_reg];

    // A new key must evict when the store is full or already holds the
    // configured capacity. A limit above ENTRIES reduces to the full test.
    assign do_evict = (count_reg >= CW'(ENTRIES))
                   || (32'(count_reg) >= 32'(limit_reg));
    assign new_slot = do_evict ? lru_slot_reg : free_slot_reg;

    assign res_load = (state_reg == ST_DONE) && (!res_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == AW'(ENTRIES - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Recency and occupancy update. On a hit, every entry more recent than
    // the hit entry ages by one; on an insert, every valid entry ages by one.
    // An evicted entry is reused in place, so its valid bit stays set.
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        mem_waddr  = hit_slot_reg;
        if (state_reg == ST_UPDATE)
        begin
            if (found_reg)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i] && (rank_reg[i] < hit_rank_reg))
                    begin
                        rank_next[i] = rank_reg[i] + RW'(1);
                    end
                end
                rank_next[hit_slot_reg] = '0;
                mem_we = (kind_reg == KIND_PUT);
            end
            else if ((kind_reg == KIND_PUT) && !(do_evict && (count_reg == '0)))
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + RW'(1);
                    end
                end
                valid_next[new_slot] = 1'b1;
                rank_next[new_slot]  = '0;
                mem_we    = 1'b1;
                mem_waddr = new_slot;
                if (!do_evict)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= CAP_RESET;
            valid_reg     <= '0;
            count_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            rank_reg    <= rank_next;
            count_reg   <= count_next;
            cmp_vld_reg <= (state_reg == ST_SCAN);
            if (cap_cfg.valid)
            begin
                limit_reg <= cap_cfg.capacity_limit;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            kind_reg       <= request.kind;
            key_reg        <= request.lookup_key;
            wval_reg       <= request.write_value[VALUE_BITS-1:0];
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            lru_slot_reg   <= '0;
            free_slot_reg  <= '0;
        end
        if (state_reg == ST_SCAN)
        begin
            scan_idx_reg <= scan_idx_reg + AW'(1);
            cmp_idx_reg  <= scan_idx_reg;
        end
        if (cmp_vld_reg)
        begin
            // First matching valid entry wins.
            if (!found_reg && cmp_entry_valid && (mem_rd_key == key_reg))
            begin
                found_reg    <= 1'b1;
                hit_slot_reg <= cmp_idx_reg;
                hit_rank_reg <= cmp_entry_rank;
                hit_val_reg  <= mem_rd_value;
            end
            // The least recent valid entry holds rank count - 1.
            if (cmp_entry_valid && ((CW'(cmp_entry_rank) + CW'(1)) == count_reg))
            begin
                lru_slot_reg <= cmp_idx_reg;
            end
            // Lowest-numbered free slot.
            if (!free_found_reg && !cmp_entry_valid)
            begin
                free_found_reg <= 1'b1;
                free_slot_reg  <= cmp_idx_reg;
            end
        end
        if (res_load)
        begin
            res_hit_reg   <= found_reg;
            res_value_reg <= found_reg ? WORD_BITS'(hit_val_reg) : '0;
        end
    end

    // The fill count always agrees with the number of occupied slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(count_reg))
        else $error("entry count differs from occupied slots");

    // The count never exceeds the store size.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(ENTRIES))
        else $error("entry count above store size");

    // A hit found by the scan always points at an occupied slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) && found_reg |-> valid_reg[hit_slot_reg])
        else $error("hit on an empty slot");

    // An accepted request always starts a scan in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        request.valid && request.ready |=> (state_reg == ST_SCAN) && (scan_idx_reg == '0))
        else $error("scan did not start after a request");

endmodule

`default_nettype wire
